FILE: rtl/core/dcps_pkg.sv
// Shared types, constants and register map of the DC clock PI sync block.
package dcps_pkg;

   localparam int TIME_W     = 63;
   localparam int OFFSET_W   = 64;
   localparam int ERR_W      = 31;
   localparam int PERIOD_W   = 30;
   localparam int GAIN_W     = 16;
   localparam int SHIFT_W    = 4;
   localparam int DVD_W      = 64;
   localparam int CNT_W      = 6;
   localparam int PROD_W     = ERR_W + GAIN_W + 1;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Reset values; the gains are 0.05 and 0.01 in Q15
   localparam logic [PERIOD_W-1:0]      CYCLE_PERIOD_RST = 30'd1000000;
   localparam logic signed [ERR_W-1:0]  PHASE_SHIFT_RST  = 31'sd480000;
   localparam logic [GAIN_W-1:0]        PROP_GAIN_RST    = 16'd1638;
   localparam logic [SHIFT_W-1:0]       PROP_SHIFT_RST   = 4'd15;
   localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST   = 16'd327;
   localparam logic [SHIFT_W-1:0]       INTEG_SHIFT_RST  = 4'd15;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_CYCLE_PERIOD = 3'd0,
      REG_PHASE_SHIFT  = 3'd1,
      REG_PROP_GAIN    = 3'd2,
      REG_PROP_SHIFT   = 3'd3,
      REG_INTEG_GAIN   = 3'd4,
      REG_INTEG_SHIFT  = 3'd5
   } dcps_reg_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]     cycle_period;
      logic signed [ERR_W-1:0] phase_shift;
      logic [GAIN_W-1:0]       prop_gain;
      logic [SHIFT_W-1:0]      prop_shift;
      logic [GAIN_W-1:0]       integ_gain;
      logic [SHIFT_W-1:0]      integ_shift;
   } dcps_cfg_type;

   typedef struct packed {
      logic err_en;
      logic mul_en;
      logic acc_en;
   } dcps_pi_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULT,
      ST_ACCUM,
      ST_OUTPUT
   } dcps_state_type;

endpackage

FILE: rtl/core/dcps_req_if.sv
// Input channel: one DC time sample per item.
interface dcps_req_if;
   import dcps_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] dc_time;

   modport source (output valid, output dc_time, input ready);
   modport sink   (input valid, input dc_time, output ready);
endinterface

FILE: rtl/core/dcps_rsp_if.sv
// Result channel: timer offset and phase error per item.
interface dcps_rsp_if;
   import dcps_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [OFFSET_W-1:0] wake_adjust;
   logic signed [ERR_W-1:0]    phase_error;

   modport source (output valid, output wake_adjust, output phase_error, input ready);
   modport sink   (input valid, input wake_adjust, input phase_error, output ready);
endinterface

FILE: rtl/core/dc_clock_pi_sync.sv
// Top level of the DC clock PI sync block.
//
// Usage: one DC time sample (dc_time) enters per bus cycle on req_chan; the
// block answers each item with one rsp_chan item holding the timer offset for
// the next wake time and the wrapped phase error used.
// The phase error is the signed remainder of (dc_time - phase_shift) by
// cycle_period, folded into (-period, period/2]. The integral accumulator
// gains error * integ_gain; the offset is -(P term) - (I term).
// The time per item is set by the bit-serial remainder loop, one dividend
// bit a cycle over 64 bits, plus error wrap, multiply, accumulate and output
// steps; the next item is taken only after the result is loaded.
// A finished result sits in the output register; a new item may be accepted
// and worked on while it waits. If the receiver still stalls when the next
// result is done, the block holds it and accepts nothing further.
// Reset (synchronous, active high) restores the register defaults, clears
// the integral accumulator and drops any item in flight.
// Registers are on the APB port, one per 32-bit word; write only when idle.
module dc_clock_pi_sync (
   input  logic                             clock,
   input  logic                             reset,
   dcps_req_if.sink                         req_chan,
   dcps_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dcps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dcps_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dcps_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import dcps_pkg::*;

   dcps_cfg_type               cfg;
   dcps_pi_ctl_type            pi_ctl;
   dcps_state_type             state_ff, state_in;

   logic                       accept;
   logic                       neg_ff;
   logic                       rem_done;
   logic [PERIOD_W-1:0]        rem_val;
   logic [DVD_W:0]             diff;
   logic                       diff_neg;
   logic [PERIOD_W-1:0]        small_mag;
   logic [DVD_W-1:0]           mag;
   logic signed [ERR_W-1:0]    pi_err;
   logic signed [OFFSET_W-1:0] pi_offset;
   logic                       out_load;
   logic                       rsp_valid_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic signed [ERR_W-1:0]    err_out_ff;

   dcps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Exact dividend: dc_time minus sign-extended phase shift, 65 bits.
   // A negative difference only happens for 0 < phase_shift, dc_time <
   // phase_shift, so its magnitude fits in the low 30 bits.
   assign diff      = {2'b00, req_chan.dc_time} - (DVD_W + 1)'(cfg.phase_shift);
   assign diff_neg  = diff[DVD_W];
   assign small_mag = cfg.phase_shift[PERIOD_W-1:0] - req_chan.dc_time[PERIOD_W-1:0];
   assign mag       = diff_neg ? DVD_W'(small_mag) : diff[DVD_W-1:0];

   assign accept = req_chan.valid & req_chan.ready;

   always_ff @(posedge clock) begin
      if (accept) neg_ff <= diff_neg;
   end

   dcps_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (mag),
      .period    (cfg.cycle_period),
      .done      (rem_done),
      .remainder (rem_val)
   );

   dcps_pi u_pi (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .ctl    (pi_ctl),
      .rem    (rem_val),
      .neg    (neg_ff),
      .err    (pi_err),
      .offset (pi_offset)
   );

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_chan.valid) state_in = ST_DIVIDE;
         ST_DIVIDE: if (rem_done) state_in = ST_MULT;
         ST_MULT:   state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_OUTPUT;
         ST_OUTPUT: if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_chan.ready = 1'b0;
      pi_ctl         = '0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_DIVIDE: pi_ctl.err_en  = rem_done;
         ST_MULT:   pi_ctl.mul_en  = 1'b1;
         ST_ACCUM:  pi_ctl.acc_en  = 1'b1;
         ST_OUTPUT: out_load       = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         offset_ff  <= pi_offset;
         err_out_ff <= pi_err;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.wake_adjust = offset_ff;
   assign rsp_chan.phase_error = err_out_ff;

   a_accept_divide: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIVIDE)
      else $error("accepted item did not start the remainder loop");
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> state_ff == ST_DIVIDE)
      else $error("remainder finished outside the divide step");
   a_load_from_output: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result load did not fill the output register");

endmodule

FILE: rtl/core/dcps_csr.sv
// APB-style configuration register file.
module dcps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dcps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dcps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dcps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output dcps_pkg::dcps_cfg_type              cfg
);
   import dcps_pkg::*;

   dcps_cfg_type             cfg_ff;
   logic                     wr_en;
   logic [REG_IDX_W-1:0]     idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycle_period <= CYCLE_PERIOD_RST;
         cfg_ff.phase_shift  <= PHASE_SHIFT_RST;
         cfg_ff.prop_gain    <= PROP_GAIN_RST;
         cfg_ff.prop_shift   <= PROP_SHIFT_RST;
         cfg_ff.integ_gain   <= INTEG_GAIN_RST;
         cfg_ff.integ_shift  <= INTEG_SHIFT_RST;
      end else if (wr_en) begin
         case (dcps_reg_type'(idx))
            REG_CYCLE_PERIOD: cfg_ff.cycle_period <= csr_pwdata[PERIOD_W-1:0];
            REG_PHASE_SHIFT:  cfg_ff.phase_shift  <= $signed(csr_pwdata[ERR_W-1:0]);
            REG_PROP_GAIN:    cfg_ff.prop_gain    <= csr_pwdata[GAIN_W-1:0];
            REG_PROP_SHIFT:   cfg_ff.prop_shift   <= csr_pwdata[SHIFT_W-1:0];
            REG_INTEG_GAIN:   cfg_ff.integ_gain   <= csr_pwdata[GAIN_W-1:0];
            REG_INTEG_SHIFT:  cfg_ff.integ_shift  <= csr_pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (dcps_reg_type'(idx))
         REG_CYCLE_PERIOD: csr_prdata[PERIOD_W-1:0] = cfg_ff.cycle_period;
         REG_PHASE_SHIFT:  csr_prdata[ERR_W-1:0]    = cfg_ff.phase_shift;
         REG_PROP_GAIN:    csr_prdata[GAIN_W-1:0]   = cfg_ff.prop_gain;
         REG_PROP_SHIFT:   csr_prdata[SHIFT_W-1:0]  = cfg_ff.prop_shift;
         REG_INTEG_GAIN:   csr_prdata[GAIN_W-1:0]   = cfg_ff.integ_gain;
         REG_INTEG_SHIFT:  csr_prdata[SHIFT_W-1:0]  = cfg_ff.integ_shift;
         default:          csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/dcps_rem.sv
// Bit-serial restoring remainder: 64-bit dividend by 30-bit period.
module dcps_rem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dcps_pkg::DVD_W-1:0]        dividend,
   input  logic [dcps_pkg::PERIOD_W-1:0]     period,
   output logic                              done,
   output logic [dcps_pkg::PERIOD_W-1:0]     remainder
);
   import dcps_pkg::*;

   logic [DVD_W-1:0]    dvd_ff;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff, done_ff;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W+1:0] trial;
   logic                last;

   // one dividend bit per cycle, MSB first
   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, period};
   assign rem_in  = trial[PERIOD_W+1] ? shifted[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
   assign last    = (cnt_ff == CNT_W'(DVD_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff & last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("remainder unit not busy after start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder done while still iterating");

endmodule

FILE: rtl/core/dcps_pi.sv
// Phase error wrap, PI products, integral accumulator and offset sum.
module dcps_pi (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dcps_pkg::dcps_cfg_type                cfg,
   input  dcps_pkg::dcps_pi_ctl_type             ctl,
   input  logic [dcps_pkg::PERIOD_W-1:0]         rem,
   input  logic                                  neg,
   output logic signed [dcps_pkg::ERR_W-1:0]     err,
   output logic signed [dcps_pkg::OFFSET_W-1:0]  offset
);
   import dcps_pkg::*;

   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [PROD_W-1:0]   pprod_ff, iprod_ff;
   logic signed [PROD_W-1:0]   pneg_ff;
   logic signed [OFFSET_W-1:0] acc_ff;
   logic signed [GAIN_W:0]     pgain_s, igain_s;

   // wrap the truncated remainder into (-period, period/2]
   always_comb begin
      if (cfg.cycle_period == '0)
         err_in = '0;
      else if (neg)
         err_in = -$signed({1'b0, rem});
      else if (rem > (cfg.cycle_period >> 1))
         err_in = $signed({1'b0, rem} - {1'b0, cfg.cycle_period});
      else
         err_in = $signed({1'b0, rem});
   end

   assign pgain_s = $signed({1'b0, cfg.prop_gain});
   assign igain_s = $signed({1'b0, cfg.integ_gain});

   always_ff @(posedge clock) begin
      if (ctl.err_en) err_ff <= err_in;
      if (ctl.mul_en) begin
         pprod_ff <= err_ff * pgain_s;
         iprod_ff <= err_ff * igain_s;
      end
      if (ctl.acc_en) pneg_ff <= -(pprod_ff >>> cfg.prop_shift);
   end

   // wraps in 64 bits, no saturation
   always_ff @(posedge clock) begin
      if (reset)
         acc_ff <= '0;
      else if (ctl.acc_en)
         acc_ff <= acc_ff + OFFSET_W'(iprod_ff);
   end

   assign err    = err_ff;
   assign offset = OFFSET_W'(pneg_ff) - (acc_ff >>> cfg.integ_shift);

endmodule
